// ===== sv/pdmd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdmd_pkg
// Shared types and constants of the peak detector with minimum distance.
// ----------------------------------------------------------------------------
`default_nettype none

package pdmd_pkg;

   localparam int THR_BITS      = 16;
   localparam int SEP_BITS      = 7;
   localparam int POS_BITS      = 7;
   localparam int CSR_IDX_BITS  = 4;
   localparam int CSR_DATA_BITS = 16;
   localparam int MIN_FRAME     = 3;

   localparam logic [CSR_IDX_BITS-1:0] CSR_THRESHOLD  = 4'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SEPARATION = 4'd1;

   // separations up to this value leave every candidate kept
   localparam logic [SEP_BITS-1:0] SEP_OFF_MAX = 7'd1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT_SCAN,
      ST_EMIT_READ,
      ST_OUT
   } state_type;

endpackage

`default_nettype wire

// ===== sv/pdmd_sample_buf.sv =====
// ----------------------------------------------------------------------------
// pdmd_sample_buf
// Frame sample store with registered read, plus a three-sample window that
// flags a thresholded strict local maximum at the previous stored sample.
// ----------------------------------------------------------------------------
`default_nettype none

module pdmd_sample_buf #(
   parameter int SAMPLE_BITS = 16,
   parameter int FRAME_DEPTH = 128
) (
   input  wire logic                                clock,
   input  wire logic                                wr_en,
   input  wire logic [$clog2(FRAME_DEPTH)-1:0]      wr_addr,
   input  wire logic signed [SAMPLE_BITS-1:0]       wr_data,
   input  wire logic [$clog2(FRAME_DEPTH)-1:0]      rd_addr,
   input  wire logic signed [pdmd_pkg::THR_BITS-1:0] threshold,
   output logic signed [SAMPLE_BITS-1:0]            rd_data,
   output logic                                     mid_is_peak
);

   localparam int CMP_W = (SAMPLE_BITS > pdmd_pkg::THR_BITS) ?
                          SAMPLE_BITS : pdmd_pkg::THR_BITS;

   logic signed [SAMPLE_BITS-1:0] store_ff [FRAME_DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [SAMPLE_BITS-1:0] win1_ff;
   logic signed [SAMPLE_BITS-1:0] win2_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         win2_ff <= win1_ff;
         win1_ff <= wr_data;
      end
   end

   assign rd_data     = rd_data_ff;
   assign mid_is_peak = (win1_ff > win2_ff) && (win1_ff > wr_data) &&
                        (CMP_W'(win1_ff) >= CMP_W'(threshold));

endmodule

`default_nettype wire

// ===== sv/peak_detect_min_distance.sv =====
// ----------------------------------------------------------------------------
// peak_detect_min_distance
// Frame peak finder: thresholded strict local maxima, greedy suppression of
// peaks no farther than the separation, results in ascending position.
// ----------------------------------------------------------------------------
// Samples transfer at one per cycle while loading; candidates are marked on
// the fly. After the frame-end transfer the block is busy. With suppression
// off it scans the marks once. With the separation above 1 each greedy
// round sweeps the sample store through its single read port with one
// maximum comparator; K kept peaks take K + 1 rounds before the output
// scan starts. Each result is held in the output register until taken;
// the next frame transfers after the last result of the frame is taken.
// Register writes transfer only while the block is idle between frames.
`default_nettype none

module peak_detect_min_distance #(
   parameter int FRAME_DEPTH = 128,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   // tdata: sample_value
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]                      req_tdata,
   input  wire logic                                                  req_tvalid,
   output logic                                                       req_tready,
   input  wire logic                                                  req_tlast,
   // tdata: peak_position, peak_height
   output logic [((pdmd_pkg::POS_BITS+SAMPLE_BITS+7)/8)*8-1:0]        rsp_tdata,
   // tuser: peak_valid
   output logic                                                       rsp_tuser,
   output logic                                                       rsp_tvalid,
   input  wire logic                                                  rsp_tready,
   output logic                                                       rsp_tlast,
   input  wire logic                                                  csr_valid,
   output logic                                                       csr_ready,
   input  wire logic [pdmd_pkg::CSR_IDX_BITS-1:0]                     csr_index,
   input  wire logic [pdmd_pkg::CSR_DATA_BITS-1:0]                    csr_data
);

   localparam int IDX_W = $clog2(FRAME_DEPTH);
   localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
   localparam int DW    = ((CNT_W > pdmd_pkg::SEP_BITS) ? CNT_W : pdmd_pkg::SEP_BITS) + 1;
   localparam int RSP_W = ((pdmd_pkg::POS_BITS + SAMPLE_BITS + 7) / 8) * 8;

   pdmd_pkg::state_type state_ff, state_in;

   logic signed [pdmd_pkg::THR_BITS-1:0] thr_ff;
   logic [pdmd_pkg::SEP_BITS-1:0]        sep_ff;

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]       tot_ff, tot_in;
   logic [CNT_W-1:0]       emitted_ff, emitted_in;
   logic [FRAME_DEPTH-1:0] cand_ff, cand_in;
   logic [FRAME_DEPTH-1:0] supp_ff, supp_in;
   logic [FRAME_DEPTH-1:0] kept_ff, kept_in;
   logic [FRAME_DEPTH-1:0] win_mask;

   logic                          pend_ff, pend_in;
   logic [IDX_W-1:0]              pend_idx_ff, pend_idx_in;
   logic                          found_ff, found_in;
   logic [IDX_W-1:0]              best_idx_ff, best_idx_in;
   logic signed [SAMPLE_BITS-1:0] best_val_ff, best_val_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pdmd_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic [SAMPLE_BITS-1:0]        height_ff, height_in;
   logic                          pvalid_ff, pvalid_in;
   logic                          last_ff, last_in;

   logic                          req_fire;
   logic                          store_ok;
   logic                          wr_en;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic                          mid_is_peak;
   logic                          new_cand;
   logic [CNT_W-1:0]              n_len;
   logic [IDX_W-1:0]              sidx;
   logic                          in_range;
   logic                          go_invalid;
   logic                          finish;

   assign sample   = $signed(req_tdata[SAMPLE_BITS-1:0]);
   assign req_fire = req_tvalid && req_tready;
   assign store_ok = count_ff < CNT_W'(FRAME_DEPTH);
   assign wr_en    = req_fire && store_ok;
   assign new_cand = wr_en && (count_ff >= CNT_W'(2)) && mid_is_peak;
   assign n_len    = store_ok ? count_ff + CNT_W'(1) : count_ff;
   assign sidx     = scan_ff[IDX_W-1:0];
   assign in_range = scan_ff < n_ff;

   pdmd_sample_buf #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAME_DEPTH (FRAME_DEPTH)
   ) u_buf (
      .clock       (clock),
      .wr_en       (wr_en),
      .wr_addr     (count_ff[IDX_W-1:0]),
      .wr_data     (sample),
      .rd_addr     (sidx),
      .threshold   (thr_ff),
      .rd_data     (rd_data),
      .mid_is_peak (mid_is_peak)
   );

   // suppression window around the current best peak
   always_comb begin
      for (int j = 0; j < FRAME_DEPTH; j++) begin
         win_mask[j] = (DW'(j) + DW'(sep_ff) >= DW'(best_idx_ff)) &&
                       (DW'(j) <= DW'(best_idx_ff) + DW'(sep_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= '0;
         sep_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pdmd_pkg::CSR_THRESHOLD:  thr_ff <= $signed(csr_data[pdmd_pkg::THR_BITS-1:0]);
            pdmd_pkg::CSR_SEPARATION: sep_ff <= csr_data[pdmd_pkg::SEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pdmd_pkg::ST_LOAD;
         count_ff     <= '0;
         tot_ff       <= '0;
         emitted_ff   <= '0;
         cand_ff      <= '0;
         supp_ff      <= '0;
         kept_ff      <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tot_ff       <= tot_in;
         emitted_ff   <= emitted_in;
         cand_ff      <= cand_in;
         supp_ff      <= supp_in;
         kept_ff      <= kept_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      pos_ff      <= pos_in;
      height_ff   <= height_in;
      pvalid_ff   <= pvalid_in;
      last_ff     <= last_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      scan_in      = scan_ff;
      tot_in       = tot_ff;
      emitted_in   = emitted_ff;
      cand_in      = cand_ff;
      supp_in      = supp_ff;
      kept_in      = kept_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      rsp_valid_in = rsp_valid_ff;
      pos_in       = pos_ff;
      height_in    = height_ff;
      pvalid_in    = pvalid_ff;
      last_in      = last_ff;
      go_invalid   = 1'b0;
      finish       = 1'b0;

      case (state_ff)
         pdmd_pkg::ST_LOAD: begin
            if (req_fire) begin
               if (new_cand) begin
                  cand_in[IDX_W'(count_ff - CNT_W'(1))] = 1'b1;
                  tot_in = tot_ff + CNT_W'(1);
               end
               if (store_ok) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_tlast) begin
                  count_in   = '0;
                  n_in       = n_len;
                  scan_in    = '0;
                  found_in   = 1'b0;
                  emitted_in = '0;
                  if (n_len < CNT_W'(pdmd_pkg::MIN_FRAME)) begin
                     go_invalid = 1'b1;
                  end else if (sep_ff > pdmd_pkg::SEP_OFF_MAX) begin
                     tot_in   = '0;
                     state_in = pdmd_pkg::ST_SCAN;
                  end else if (tot_in == '0) begin
                     go_invalid = 1'b1;
                  end else begin
                     kept_in  = cand_in;
                     state_in = pdmd_pkg::ST_EMIT_SCAN;
                  end
               end
            end
         end
         pdmd_pkg::ST_SCAN: begin
            if (in_range) begin
               pend_in     = cand_ff[sidx] && !supp_ff[sidx];
               pend_idx_in = sidx;
               scan_in     = scan_ff + CNT_W'(1);
            end
            if (pend_ff && (!found_ff || rd_data > best_val_ff)) begin
               found_in    = 1'b1;
               best_idx_in = pend_idx_ff;
               best_val_in = rd_data;
            end
            if (!in_range && !pend_ff) begin
               scan_in = '0;
               if (found_ff) begin
                  kept_in[best_idx_ff] = 1'b1;
                  supp_in  = supp_ff | win_mask;
                  tot_in   = tot_ff + CNT_W'(1);
                  found_in = 1'b0;
               end else if (tot_ff == '0) begin
                  go_invalid = 1'b1;
               end else begin
                  state_in = pdmd_pkg::ST_EMIT_SCAN;
               end
            end
         end
         pdmd_pkg::ST_EMIT_SCAN: begin
            if (in_range) begin
               scan_in = scan_ff + CNT_W'(1);
               if (kept_ff[sidx]) begin
                  pos_in   = pdmd_pkg::POS_BITS'(sidx);
                  state_in = pdmd_pkg::ST_EMIT_READ;
               end
            end else begin
               finish = 1'b1;
            end
         end
         pdmd_pkg::ST_EMIT_READ: begin
            height_in    = rd_data;
            pvalid_in    = 1'b1;
            emitted_in   = emitted_ff + CNT_W'(1);
            last_in      = (emitted_ff + CNT_W'(1)) == tot_ff;
            rsp_valid_in = 1'b1;
            state_in     = pdmd_pkg::ST_OUT;
         end
         pdmd_pkg::ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  finish = 1'b1;
               end else begin
                  state_in = pdmd_pkg::ST_EMIT_SCAN;
               end
            end
         end
         default: begin
            finish = 1'b1;
         end
      endcase

      if (go_invalid) begin
         pos_in       = '0;
         height_in    = '0;
         pvalid_in    = 1'b0;
         last_in      = 1'b1;
         rsp_valid_in = 1'b1;
         state_in     = pdmd_pkg::ST_OUT;
      end

      if (finish) begin
         state_in   = pdmd_pkg::ST_LOAD;
         cand_in    = '0;
         supp_in    = '0;
         kept_in    = '0;
         tot_in     = '0;
         emitted_in = '0;
         found_in   = 1'b0;
      end
   end

   assign req_tready = (state_ff == pdmd_pkg::ST_LOAD);
   assign csr_ready  = (state_ff == pdmd_pkg::ST_LOAD) && (count_ff == '0);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({height_ff, pos_ff});
   assign rsp_tuser  = pvalid_ff;
   assign rsp_tlast  = last_ff;

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> !req_tready)
      else $error("frame end transfer did not start detection");

   a_invalid_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> rsp_tlast)
      else $error("invalid result not marked last");

   a_kept_are_cand: assert property (@(posedge clock) disable iff (reset)
      (kept_ff & ~cand_ff) == '0)
      else $error("kept peak without candidate mark");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      emitted_ff <= tot_ff)
      else $error("more results than kept peaks");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for peak_detect_min_distance. Frames of samples are
// streamed in, a behavioral peak finder computes the kept peaks of each
// frame, and every result transfer is compared field by field against the
// oldest expected peak. A directed table runs first; random phases follow
// with different threshold and separation settings, random frame lengths and
// shapes, one over-length frame, and random gaps on both streams.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_DEPTH = 128;
   localparam int SAMPLE_BITS = 16;
   localparam int SETTLE_CYCLES = 20;
   localparam int TAIL_CYCLES = 100;

   typedef struct packed {
      logic [pdmd_pkg::POS_BITS-1:0] position;
      logic [SAMPLE_BITS-1:0]        height;
      logic                          valid;
      logic                          run_last;
   } peak_result_type;

   typedef struct packed {
      bit                            setup;
      logic [pdmd_pkg::THR_BITS-1:0] thr;
      logic [pdmd_pkg::SEP_BITS-1:0] sep;
      logic [SAMPLE_BITS-1:0]        sample;
      bit                            fin;
      bit                            typed;
      logic [pdmd_pkg::POS_BITS-1:0] want_pos;
      logic [SAMPLE_BITS-1:0]        want_height;
      bit                            want_valid;
   } stim_row_type;

   typedef enum int {
      STYLE_WIDE, STYLE_TIES, STYLE_COMB, STYLE_EDGE, STYLE_RAIL
   } wave_style_type;

   // setup, thr, sep, sample, frame end, typed, position, height, valid
   localparam stim_row_type DIRECTED [0:24] = '{
      '{0, 0, 0, 16'h7FFF, 1, 1, 0, 16'h0000, 0},   // one-sample frame
      '{0, 0, 0, 16'h8000, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h7FFF, 1, 1, 0, 16'h0000, 0},   // two-sample frame
      '{0, 0, 0, 16'h8000, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h7FFF, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h8000, 1, 1, 1, 16'h7FFF, 1},   // full-scale peak
      '{0, 0, 0, 16'h0005, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0005, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0005, 1, 1, 0, 16'h0000, 0},   // flat, not strict
      '{0, 0, 0, 16'hFFFB, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0000, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'hFFFB, 1, 1, 1, 16'h0000, 1},   // peak equal to threshold
      '{0, 0, 0, 16'h0000, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0064, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0000, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h00C8, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0000, 1, 0, 0, 16'h0000, 0},
      '{1, 16'h8000, 2, 16'h0000, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0032, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0000, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0032, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0000, 1, 0, 0, 16'h0000, 0},   // equal heights, lower index wins
      '{0, 0, 0, 16'h0064, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0000, 0, 0, 0, 16'h0000, 0},
      '{0, 0, 0, 16'h0064, 1, 1, 0, 16'h0000, 0}    // frame ends never count
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [15:0] req_tdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tlast = 1'b0;
   logic req_tready;
   logic [23:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pdmd_pkg::CSR_IDX_BITS-1:0] csr_index = '0;
   logic [pdmd_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   // peak finder state
   logic signed [SAMPLE_BITS-1:0] frame_store [FRAME_DEPTH];
   int frame_fill = 0;
   logic signed [pdmd_pkg::THR_BITS-1:0] threshold = '0;
   logic [pdmd_pkg::SEP_BITS-1:0] separation = '0;
   peak_result_type fresh_peaks[$];
   peak_result_type expected_peaks[$];

   bit steady = 1'b0;
   int failures = 0;
   int samples_sent = 0;
   int frames_sent = 0;
   int dropped_samples = 0;
   int settings_used = 0;
   int peaks_seen = 0;
   int empty_seen = 0;

   peak_detect_min_distance #(
      .FRAME_DEPTH(FRAME_DEPTH),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tlast(req_tlast),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void find_peaks(input int n);
      bit cand [FRAME_DEPTH];
      bit covered [FRAME_DEPTH];
      bit kept [FRAME_DEPTH];
      int best, lo, hi, total, seen, sep;
      bit found;
      peak_result_type r;
      cand = '{default: 1'b0};
      covered = '{default: 1'b0};
      kept = '{default: 1'b0};
      sep = separation;
      total = 0;
      seen = 0;
      for (int i = 1; i + 1 < n; i++) begin
         if (frame_store[i] > frame_store[i-1] && frame_store[i] > frame_store[i+1] &&
             frame_store[i] >= threshold) begin
            cand[i] = 1'b1;
         end
      end
      if (sep > pdmd_pkg::SEP_OFF_MAX) begin
         found = 1'b1;
         while (found) begin
            found = 1'b0;
            best = 0;
            for (int i = 0; i < n; i++) begin
               if (cand[i] && !covered[i] && (!found || frame_store[i] > frame_store[best])) begin
                  best = i;
                  found = 1'b1;
               end
            end
            if (found) begin
               kept[best] = 1'b1;
               lo = (best > sep) ? best - sep : 0;
               hi = (best + sep > n - 1) ? n - 1 : best + sep;
               for (int j = lo; j <= hi; j++) covered[j] = 1'b1;
            end
         end
      end else begin
         kept = cand;
      end
      for (int i = 0; i < n; i++) total += kept[i];
      if (n < pdmd_pkg::MIN_FRAME || total == 0) begin
         r.position = '0;
         r.height = '0;
         r.valid = 1'b0;
         r.run_last = 1'b1;
         fresh_peaks = {fresh_peaks, r};
      end else begin
         for (int i = 0; i < n; i++) begin
            if (kept[i]) begin
               seen++;
               r.position = pdmd_pkg::POS_BITS'(i);
               r.height = frame_store[i];
               r.valid = 1'b1;
               r.run_last = (seen == total);
               fresh_peaks = {fresh_peaks, r};
            end
         end
      end
   endfunction

   function automatic void take_sample(input logic [SAMPLE_BITS-1:0] s, input bit fin);
      int n;
      fresh_peaks.delete();
      if (frame_fill < FRAME_DEPTH) begin
         frame_store[frame_fill] = s;
         frame_fill++;
      end else begin
         dropped_samples++;
      end
      if (fin) begin
         n = frame_fill;
         frame_fill = 0;
         find_peaks(n);
      end
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return $urandom_range(1, pdmd_pkg::MIN_FRAME - 1);
      if (r < 85) return $urandom_range(pdmd_pkg::MIN_FRAME, 12);
      if (r < 97) return $urandom_range(13, 40);
      return $urandom_range(60, FRAME_DEPTH);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] make_sample(input wave_style_type style,
                                                          input int idx);
      int v;
      case (style)
         STYLE_TIES: v = int'($urandom_range(0, 8)) - 4;
         STYLE_COMB: begin
            if (idx % 2 == 1) v = $urandom_range(1000, 32767);
            else v = int'($urandom_range(0, 33767)) - 32768;
         end
         STYLE_EDGE: begin
            v = int'(threshold) + int'($urandom_range(0, 4)) - 2;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
         end
         STYLE_RAIL: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = -32767;
               2: v = 32766;
               default: v = 32767;
            endcase
         end
         default: v = $urandom;
      endcase
      return SAMPLE_BITS'(v);
   endfunction

   task automatic send_item(input logic [SAMPLE_BITS-1:0] s, input bit fin, input bit typed,
                            input peak_result_type typed_want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= s;
      req_tlast <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      take_sample(s, fin);
      if (typed) expected_peaks = {expected_peaks, typed_want};
      else expected_peaks = {expected_peaks, fresh_peaks};
      samples_sent++;
      if (fin) frames_sent++;
   endtask

   task automatic send_frame(input int len, input wave_style_type style);
      for (int i = 0; i < len; i++) send_item(make_sample(style, i), i == len - 1, 1'b0, '0);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_peaks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // stray index first, then both real registers
   task automatic program_settings(input logic [pdmd_pkg::THR_BITS-1:0] thr,
                                   input logic [pdmd_pkg::SEP_BITS-1:0] sep);
      logic [pdmd_pkg::CSR_IDX_BITS-1:0] idx [3];
      logic [pdmd_pkg::CSR_DATA_BITS-1:0] val [3];
      idx[0] = pdmd_pkg::CSR_IDX_BITS'($urandom_range(pdmd_pkg::CSR_SEPARATION + 1,
                                                      (1 << pdmd_pkg::CSR_IDX_BITS) - 1));
      val[0] = pdmd_pkg::CSR_DATA_BITS'($urandom);
      idx[1] = pdmd_pkg::CSR_THRESHOLD;
      val[1] = thr;
      idx[2] = pdmd_pkg::CSR_SEPARATION;
      val[2] = {(pdmd_pkg::CSR_DATA_BITS - pdmd_pkg::SEP_BITS)'($urandom), sep};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (idx[k] == pdmd_pkg::CSR_THRESHOLD) begin
            threshold = val[k][pdmd_pkg::THR_BITS-1:0];
         end else if (idx[k] == pdmd_pkg::CSR_SEPARATION) begin
            separation = val[k][pdmd_pkg::SEP_BITS-1:0];
         end
      end
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin : result_sink
      int stall;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_results
      peak_result_type want;
      logic [pdmd_pkg::POS_BITS-1:0] got_pos;
      logic [SAMPLE_BITS-1:0] got_height;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_pos = rsp_tdata[pdmd_pkg::POS_BITS-1:0];
         got_height = rsp_tdata[pdmd_pkg::POS_BITS +: SAMPLE_BITS];
         if (expected_peaks.size() == 0) begin
            $error("unexpected result: position %0d height %0d", got_pos, $signed(got_height));
            failures++;
         end else begin
            want = expected_peaks.pop_front();
            if (want.valid) peaks_seen++;
            else empty_seen++;
            if (got_pos !== want.position) begin
               $error("peak_position: expected %0d, got %0d", want.position, got_pos);
               failures++;
            end
            if (got_height !== want.height) begin
               $error("peak_height: expected %0d, got %0d", $signed(want.height),
                      $signed(got_height));
               failures++;
            end
            if (rsp_tuser !== want.valid) begin
               $error("peak_valid: expected %0b, got %0b", want.valid, rsp_tuser);
               failures++;
            end
            if (rsp_tlast !== want.run_last) begin
               $error("run_last: expected %0b, got %0b", want.run_last, rsp_tlast);
               failures++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : stimulus
      peak_result_type typed_want;
      logic [pdmd_pkg::THR_BITS-1:0] thr;
      logic [pdmd_pkg::SEP_BITS-1:0] sep;
      int phase, base_samples, start;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[r]) begin
         if (DIRECTED[r].setup) begin
            wait_idle();
            program_settings(DIRECTED[r].thr, DIRECTED[r].sep);
         end
         typed_want.position = DIRECTED[r].want_pos;
         typed_want.height = DIRECTED[r].want_height;
         typed_want.valid = DIRECTED[r].want_valid;
         typed_want.run_last = 1'b1;
         send_item(DIRECTED[r].sample, DIRECTED[r].fin, DIRECTED[r].typed, typed_want);
      end

      base_samples = samples_sent;
      phase = 0;
      while (samples_sent - base_samples < 260) begin
         case (phase)
            0: begin thr = 16'h8000; sep = 0; end
            1: begin thr = 16'h7FFF; sep = 127; end
            2: begin thr = 16'h0000; sep = 1; end
            3: begin thr = 16'hFF9C; sep = 2; end
            default: begin
               case ($urandom_range(0, 5))
                  0: thr = 16'h8000;
                  1: thr = 16'h7FFF;
                  2, 3: thr = pdmd_pkg::THR_BITS'(int'($urandom_range(0, 200)) - 100);
                  default: thr = pdmd_pkg::THR_BITS'($urandom);
               endcase
               case ($urandom_range(0, 5))
                  0: sep = 0;
                  1: sep = 1;
                  2: sep = 2;
                  3: sep = pdmd_pkg::SEP_BITS'($urandom_range(3, 8));
                  4: sep = pdmd_pkg::SEP_BITS'($urandom);
                  default: sep = 127;
               endcase
            end
         endcase
         wait_idle();
         steady = (phase % 3 == 2);
         program_settings(thr, sep);
         if (phase == 0) begin
            // alternating frame, longer than the store: the most peaks a frame can give
            send_frame(FRAME_DEPTH + $urandom_range(1, 6), STYLE_COMB);
         end else begin
            start = samples_sent;
            while (samples_sent - start < 30) begin
               send_frame(pick_length(), wave_style_type'($urandom_range(0, 4)));
               if ($urandom_range(0, 9) == 0) wait_idle();
            end
         end
         phase++;
      end

      steady = 1'b0;
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run: %0d frames, %0d samples (%0d dropped past a full store), %0d settings",
               frames_sent, samples_sent, dropped_samples, settings_used);
      $display("run: %0d peaks and %0d empty-frame results compared", peaks_seen, empty_seen);
      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
